// ===== design/src_pkg.sv =====
// Package for the sensor row circle center block.
// Holds shared constants, point and job types, and config register indexes.
package src_pkg;

  localparam int unsigned NumSensorsDef = 20;

  localparam logic [11:0] MaxDistRst  = 12'd1096;
  localparam logic [5:0]  PitchRst    = 6'd50;
  localparam logic [7:0]  OffsetRst   = 8'd25;

  localparam logic [1:0] RegMaxDist = 2'd0;
  localparam logic [1:0] RegPitch   = 2'd1;
  localparam logic [1:0] RegOffset  = 2'd2;

  typedef struct packed {
    logic [12:0] y;
    logic [11:0] x;
  } point_t;

  // One finished row handed from the front to the solver.
  typedef struct packed {
    point_t [2:0] first;
    point_t [2:0] recent;
    logic [6:0]   count;
    logic [5:0]   last_id;
  } row_job_t;

endpackage

// ===== design/src_front.sv =====
// Front part: classifies readings, keeps first and latest three contact points.
// Depends on src_pkg. Emits one row job per reading marked last.
module src_front #(
  parameter int unsigned NumSensors = src_pkg::NumSensorsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [11:0]       distance_i,
  input  logic              last_i,
  input  logic [11:0]       max_dist_i,
  input  logic [5:0]        pitch_i,
  input  logic [7:0]        offset_i,
  output logic              job_valid_o,
  output src_pkg::row_job_t job_o
);
  import src_pkg::*;

  localparam logic [5:0] LastIdx = 6'(NumSensors - 1);

  logic [5:0]   idx_q;
  logic [6:0]   cnt_q;
  logic [5:0]   det_q;
  point_t [2:0] first_q;
  point_t [2:0] recent_q;

  logic         hit;
  logic [13:0]  ypos;
  point_t       pt;
  logic [6:0]   cnt_n;
  logic [5:0]   det_n;
  point_t [2:0] first_n;
  point_t [2:0] recent_n;

  always_comb begin
    hit  = distance_i < max_dist_i;
    ypos = 14'(offset_i) + 14'(pitch_i) * 14'(idx_q);
    pt.x = distance_i;
    pt.y = ypos[12:0];
    cnt_n    = cnt_q;
    det_n    = det_q;
    first_n  = first_q;
    recent_n = recent_q;
    if (hit) begin
      if (cnt_q < 7'd3) first_n[cnt_q[1:0]] = pt;
      recent_n[2] = recent_q[1];
      recent_n[1] = recent_q[0];
      recent_n[0] = pt;
      if (cnt_q != 7'd127) cnt_n = cnt_q + 7'd1;
      det_n = idx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i) begin
      first_q  <= first_n;
      recent_q <= recent_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      cnt_q       <= '0;
      det_q       <= '0;
      job_valid_o <= 1'b0;
    end else begin
      job_valid_o <= take_i && last_i;
      if (take_i) begin
        if (last_i) begin
          idx_q <= '0;
          cnt_q <= '0;
          det_q <= '0;
        end else begin
          idx_q <= (idx_q >= LastIdx) ? 6'd0 : idx_q + 6'd1;
          cnt_q <= cnt_n;
          det_q <= det_n;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && last_i) begin
      job_o.first   <= first_n;
      job_o.recent  <= recent_n;
      job_o.count   <= cnt_n;
      job_o.last_id <= (cnt_n != 7'd0) ? det_n : 6'd0;
    end
  end
endmodule

// ===== design/src_div.sv =====
// Iterative unsigned divider, one quotient bit per cycle.
// Standalone; used by the solver for both centre coordinates.
module src_div #(
  parameter int unsigned NumW = 48,
  parameter int unsigned DenW = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q;
  logic            run_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [DenW:0]   trial;
  logic [DenW:0]   diff;

  always_comb begin
    trial = {rem_q[DenW-1:0], quo_o[NumW-1]};
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(NumW);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      den_q <= den_i;
      quo_o <= num_i;
    end else if (run_q) begin
      if (!diff[DenW]) begin
        rem_q <= diff;
        quo_o <= {quo_o[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_o <= {quo_o[NumW-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== design/src_solve.sv =====
// Back part: circle centre by Cramer's rule for one or two triples, then output.
// Depends on src_pkg and src_div. One multiply stage per cycle, shared divider.
module src_solve (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  src_pkg::row_job_t job_i,
  output logic              ready_o,
  output logic              done_o,
  output logic              found_o,
  output logic [15:0]       center_x_o,
  output logic [15:0]       center_y_o,
  output logic [6:0]        point_count_o,
  output logic [5:0]        last_sensor_id_o,
  output logic              any_detect_o
);
  import src_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_PREP, S_MUL1, S_MUL2, S_NUM, S_DIVX, S_DIVY, S_NEXT, S_OUT
  } state_e;

  state_e   state_q;
  row_job_t job_q;
  logic     second_q;
  logic [15:0] cx_q, cy_q;

  // Triple terms: diffs fit 15 bits signed, squares sums ~28 bits signed.
  logic signed [14:0] a1_q, b1_q, a2_q, b2_q;
  logic signed [28:0] c1_q, c2_q;
  logic signed [29:0] det_q;
  logic signed [45:0] nx_q, ny_q;
  logic signed [45:0] p1_q, p2_q, p3_q, p4_q;
  logic [45:0] nya_q;
  logic [29:0] deta_q;
  logic [45:0] quo;
  logic div_go, div_done;
  logic [45:0] div_num;

  point_t t0, t1, t2;
  logic signed [13:0] x1s, y1s, x2s, y2s, x3s, y3s;
  logic signed [27:0] sq1, sq2, sq3;
  logic [15:0] qsat;
  logic [16:0] sumx, sumy;

  always_comb begin
    t0 = second_q ? job_q.recent[0] : job_q.first[0];
    t1 = second_q ? job_q.recent[1] : job_q.first[1];
    t2 = second_q ? job_q.recent[2] : job_q.first[2];
    x1s = 14'(t0.x); y1s = {1'b0, t0.y};
    x2s = 14'(t1.x); y2s = {1'b0, t1.y};
    x3s = 14'(t2.x); y3s = {1'b0, t2.y};
    sq1 = x1s * x1s + y1s * y1s;
    sq2 = x2s * x2s + y2s * y2s;
    sq3 = x3s * x3s + y3s * y3s;
    qsat = (quo > 46'd65535) ? 16'hFFFF : quo[15:0];
    sumx = {1'b0, cx_q} + {1'b0, qsat};
    sumy = {1'b0, cy_q} + {1'b0, qsat};
    div_num = (state_q == S_NUM) ? (nx_q[45] ? 46'(-nx_q) : 46'(nx_q)) : nya_q;
  end

  assign div_go  = (state_q == S_NUM && det_q != '0) || (state_q == S_DIVX && div_done);
  assign ready_o = (state_q == S_IDLE);

  src_div #(.NumW(46), .DenW(30)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_go), .num_i(div_num), .den_i(deta_q),
    .done_o(div_done), .quo_o(quo)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_o  <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (job_valid_i) begin
            job_q    <= job_i;
            second_q <= 1'b0;
            cx_q     <= '0;
            cy_q     <= '0;
            state_q  <= (job_i.count >= 7'd3) ? S_PREP : S_OUT;
          end
        end
        S_PREP: begin
          a1_q <= 15'(-2 * (x2s - x1s)); b1_q <= 15'(-2 * (y2s - y1s));
          a2_q <= 15'(-2 * (x3s - x1s)); b2_q <= 15'(-2 * (y3s - y1s));
          c1_q <= 29'(sq2) - 29'(sq1);
          c2_q <= 29'(sq3) - 29'(sq1);
          state_q <= S_MUL1;
        end
        S_MUL1: begin
          det_q <= 30'(a1_q * b2_q) - 30'(a2_q * b1_q);
          p1_q  <= 46'(c1_q * b2_q);
          p2_q  <= 46'(c2_q * b1_q);
          state_q <= S_MUL2;
        end
        S_MUL2: begin
          p3_q <= 46'(a1_q * c2_q);
          p4_q <= 46'(a2_q * c1_q);
          nx_q <= p1_q - p2_q;
          deta_q <= det_q[29] ? 30'(-det_q) : 30'(det_q);
          state_q <= S_NUM;
        end
        S_NUM: begin
          ny_q <= p3_q - p4_q;
          if (det_q == '0) begin
            // zero determinant: centre (0,0), still averaged
            state_q <= S_NEXT;
          end else begin
            state_q <= S_DIVX;
          end
        end
        S_DIVX: begin
          nya_q <= ny_q[45] ? 46'(-ny_q) : 46'(ny_q);
          if (div_done) begin
            cx_q    <= second_q ? sumx[16:1] : qsat;
            state_q <= S_DIVY;
          end
        end
        S_DIVY: begin
          if (div_done) begin
            cy_q    <= second_q ? sumy[16:1] : qsat;
            state_q <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (det_q == '0) begin
            cx_q <= second_q ? {1'b0, cx_q[15:1]} : 16'd0;
            cy_q <= second_q ? {1'b0, cy_q[15:1]} : 16'd0;
          end
          if (!second_q && job_q.count > 7'd3) begin
            second_q <= 1'b1;
            state_q  <= S_PREP;
          end else begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          done_o           <= 1'b1;
          found_o          <= job_q.count >= 7'd3;
          center_x_o       <= cx_q;
          center_y_o       <= cy_q;
          point_count_o    <= job_q.count;
          last_sensor_id_o <= job_q.last_id;
          any_detect_o     <= job_q.count != 7'd0;
          state_q          <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== design/src_queue.sv =====
// Two-entry job queue between the front and the solver.
// Depends on src_pkg.
module src_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  src_pkg::row_job_t data_i,
  input  logic              pop_ready_i,
  output logic              valid_o,
  output src_pkg::row_job_t data_o,
  output logic              full_o
);
  import src_pkg::*;

  row_job_t mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign full_o  = cnt_q == 2'd2;
  assign pop     = valid_o && pop_ready_i;
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop};
    end
  end
endmodule

// ===== design/sensor_row_circle_center.sv =====
// Top level of the sensor row circle center block: config registers and glue.
// Depends on src_pkg, src_front, src_queue and src_solve.
// Channel  | handshake                 | payload
// item in  | start / busy              | distance_i, last_i
// config   | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
// result   | done_o (strobe)           | found_o .. any_detect_o
// A reading is taken while the job queue cannot overflow; a row end queues a job.
// Per triple the solver runs S_PREP, S_MUL1, S_MUL2 and S_NUM for setup, two divider
// runs (46 quotient bits each) and an S_NEXT wrap-up; a zero determinant skips the divider.
// done_o is registered in S_OUT, which rows under three points reach from S_IDLE;
// rows over three points run two triples. Input stalls only while two jobs would wait.
// Reset clears all control state. Results cannot be stalled.
module sensor_row_circle_center #(
  parameter int unsigned NumSensors = src_pkg::NumSensorsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [11:0] distance_i,
  input  logic        last_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  output logic        done_o,
  output logic        found_o,
  output logic [15:0] center_x_o,
  output logic [15:0] center_y_o,
  output logic [6:0]  point_count_o,
  output logic [5:0]  last_sensor_id_o,
  output logic        any_detect_o
);
  import src_pkg::*;

  logic [11:0] max_dist_q;
  logic [5:0]  pitch_q;
  logic [7:0]  offset_q;
  logic        take, jv, qv, qfull, sready;
  row_job_t    job, qjob;

  // hold off input while queue could overflow
  assign busy        = qfull || (qv && !sready && jv);
  assign take        = start && !busy;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q <= MaxDistRst;
      pitch_q    <= PitchRst;
      offset_q   <= OffsetRst;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          RegMaxDist: max_dist_q <= cfg_data_i;
          RegPitch:   pitch_q    <= cfg_data_i[5:0];
          RegOffset:  offset_q   <= cfg_data_i[7:0];
          default: ;
        endcase
      end
    end
  end

  src_front #(.NumSensors(NumSensors)) u_front (
    .clk_i, .rst_ni, .take_i(take), .distance_i, .last_i,
    .max_dist_i(max_dist_q), .pitch_i(pitch_q), .offset_i(offset_q),
    .job_valid_o(jv), .job_o(job)
  );

  src_queue u_queue (
    .clk_i, .rst_ni, .push_i(jv), .data_i(job), .pop_ready_i(sready),
    .valid_o(qv), .data_o(qjob), .full_o(qfull)
  );

  src_solve u_solve (
    .clk_i, .rst_ni, .job_valid_i(qv), .job_i(qjob), .ready_o(sready),
    .done_o(done_o), .found_o, .center_x_o, .center_y_o, .point_count_o,
    .last_sensor_id_o, .any_detect_o
  );
endmodule

// ===== sim/tb_sensor_row_circle_center.sv =====
// Testbench for sensor_row_circle_center: directed and random rows of readings with idle bursts.
// Predicts each row's circle center in-line and checks every strobed result.
// Depends on src_pkg and the sensor_row_circle_center RTL.
module tb_sensor_row_circle_center;
  import src_pkg::*;

  localparam int NumSens = 20;
  localparam int CycleLimit = 1000000;

  typedef struct packed {
    logic [11:0] distance;
    logic        last;
  } reading_t;

  typedef struct packed {
    logic        found;
    logic [15:0] cx;
    logic [15:0] cy;
    logic [6:0]  count;
    logic [5:0]  last_id;
    logic        any;
  } center_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [11:0] distance_i = '0;
  logic last_i = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [1:0] cfg_index_i = RegMaxDist;
  logic [11:0] cfg_data_i = '0;
  logic done_o;
  logic found_o;
  logic [15:0] center_x_o, center_y_o;
  logic [6:0] point_count_o;
  logic [5:0] last_sensor_id_o;
  logic any_detect_o;

  sensor_row_circle_center dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  reading_t pending_q[$];
  center_t  centers_q[$];
  logic     quiet = 1'b0;
  int       mismatches = 0;
  int       cycles = 0;

  // predictor state
  logic [11:0] max_dist;
  logic [5:0]  pitch;
  logic [7:0]  offset;
  logic [5:0]  row_idx;
  point_t      first_pt[3];
  point_t      recent_pt[3];
  logic [6:0]  contacts;
  logic [5:0]  last_det;

  function automatic logic [15:0] sat16(longint v);
    return (v > 65535) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic longint absl(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic circle_center(input point_t a, input point_t b, input point_t c,
                               output logic [15:0] cx, output logic [15:0] cy);
    longint x1, y1, x2, y2, x3, y3, a1, b1, c1, a2, b2, c2, det;
    x1 = a.x; y1 = a.y; x2 = b.x; y2 = b.y; x3 = c.x; y3 = c.y;
    a1 = -2 * (x2 - x1); b1 = -2 * (y2 - y1);
    c1 = x2 * x2 - x1 * x1 + y2 * y2 - y1 * y1;
    a2 = -2 * (x3 - x1); b2 = -2 * (y3 - y1);
    c2 = x3 * x3 - x1 * x1 + y3 * y3 - y1 * y1;
    det = a1 * b2 - a2 * b1;
    if (det == 0) begin
      cx = '0;
      cy = '0;
    end else begin
      cx = sat16(absl(c1 * b2 - c2 * b1) / absl(det));
      cy = sat16(absl(a1 * c2 - a2 * c1) / absl(det));
    end
  endtask

  task automatic take_reading(input reading_t r);
    point_t p;
    center_t res;
    logic [15:0] dx, dy;
    logic [16:0] sx, sy;
    logic [31:0] yv;
    if (r.distance < max_dist) begin
      yv = offset + pitch * row_idx;
      p.x = r.distance;
      p.y = yv[12:0];
      if (contacts < 3) first_pt[contacts] = p;
      recent_pt[2] = recent_pt[1];
      recent_pt[1] = recent_pt[0];
      recent_pt[0] = p;
      if (contacts < 127) contacts++;
      last_det = row_idx;
    end
    row_idx = (row_idx >= NumSens - 1) ? '0 : row_idx + 1'b1;
    if (r.last) begin
      res = '0;
      res.found = contacts >= 3;
      if (res.found) begin
        circle_center(first_pt[0], first_pt[1], first_pt[2], res.cx, res.cy);
        if (contacts > 3) begin
          circle_center(recent_pt[0], recent_pt[1], recent_pt[2], dx, dy);
          sx = res.cx + dx;
          sy = res.cy + dy;
          res.cx = sx[16:1];
          res.cy = sy[16:1];
        end
      end
      res.count = contacts;
      res.last_id = (contacts > 0) ? last_det : '0;
      res.any = contacts > 0;
      centers_q.push_back(res);
      row_idx = '0;
      contacts = '0;
      last_det = '0;
    end
  endtask

  // driver: hold start until accepted, insert idle bursts between items
  int gap = 0;
  reading_t cur;
  logic accepted = 1'b0;

  function automatic bit gap_next();
    if (!quiet && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 12) - 1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  always @(posedge clk_i) accepted <= start && !busy;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (start && !accepted) begin
        // hold item
      end else if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (pending_q.size() > 0 && !(start && accepted && gap_next())) begin
        cur = pending_q.pop_front();
        take_reading(cur);
        distance_i <= cur.distance;
        last_i <= cur.last;
        start <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    center_t exp_c;
    cycles <= cycles + 1;
    if (rst_ni && done_o) begin
      if (centers_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result at cycle %0d", cycles);
      end else begin
        exp_c = centers_q.pop_front();
        if (found_o !== exp_c.found || center_x_o !== exp_c.cx ||
            center_y_o !== exp_c.cy || point_count_o !== exp_c.count ||
            last_sensor_id_o !== exp_c.last_id || any_detect_o !== exp_c.any) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp f%0d x%0d y%0d n%0d id%0d a%0d got f%0d x%0d y%0d n%0d id%0d a%0d",
                     exp_c.found, exp_c.cx, exp_c.cy, exp_c.count, exp_c.last_id, exp_c.any,
                     found_o, center_x_o, center_y_o, point_count_o, last_sensor_id_o,
                     any_detect_o);
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("tb_sensor_row_circle_center failed");
      $finish;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    @(negedge clk_i);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegMaxDist: max_dist = val;
      RegPitch:   pitch = val[5:0];
      default:    offset = val[7:0];
    endcase
  endtask

  task automatic drain();
    wait (pending_q.size() == 0 && !start && centers_q.size() == 0);
    repeat (300) @(posedge clk_i);
  endtask

  task automatic push_row(input int len, input int hit_pct);
    reading_t r;
    for (int i = 0; i < len; i++) begin
      r.last = (i == len - 1);
      if ($urandom_range(0, 99) < hit_pct)
        r.distance = (max_dist > 1) ? 12'($urandom_range(0, max_dist - 1)) : 12'd0;
      else
        r.distance = 12'($urandom_range(max_dist, 4095));
      pending_q.push_back(r);
    end
  endtask

  initial begin
    max_dist = MaxDistRst;
    pitch = PitchRst;
    offset = OffsetRst;
    row_idx = '0;
    contacts = '0;
    last_det = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    // directed: empty row, two contacts, collinear triple, extremes, wrap past sensor count
    pending_q.push_back('{12'd4095, 1'b1});
    pending_q.push_back('{12'd0, 1'b0});
    pending_q.push_back('{12'd1095, 1'b0});
    pending_q.push_back('{12'd1096, 1'b1});
    pending_q.push_back('{12'd100, 1'b0});
    pending_q.push_back('{12'd100, 1'b0});
    pending_q.push_back('{12'd100, 1'b1});
    pending_q.push_back('{12'd0, 1'b0});
    pending_q.push_back('{12'd1000, 1'b0});
    pending_q.push_back('{12'd0, 1'b0});
    pending_q.push_back('{12'd1000, 1'b1});
    drain();
    write_reg(RegMaxDist, 12'd4095);
    write_reg(RegPitch, 12'd63);
    write_reg(RegOffset, 12'd255);
    push_row(24, 100);
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      if (ph == 4) quiet = 1'b1;
      write_reg(RegMaxDist, ph == 0 ? 12'd1 : 12'($urandom_range(1, 4095)));
      write_reg(RegPitch, ph == 1 ? 12'd1 : 12'($urandom_range(1, 63)));
      write_reg(RegOffset, ph == 2 ? 12'd0 : 12'($urandom_range(0, 255)));
      for (int n = 0; n < 95; ) begin
        int len;
        len = $urandom_range(1, 25);
        push_row(len, $urandom_range(0, 9) == 0 ? 10 : 70);
        n += len;
      end
      drain();
    end
    if (mismatches == 0 && centers_q.size() == 0) begin
      $display("tb_sensor_row_circle_center passed");
    end else begin
      $display("tb_sensor_row_circle_center failed");
    end
    $finish;
  end
endmodule
